[rtl/bld_pkg.sv]
// Package for the bounded list deque: sizes, codes, item and store request types.
`default_nettype none
package bld_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_BACK  = 3'd3,
    MODE_DEL_VALUE = 3'd4,
    MODE_LIST      = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  element;
    logic                     last;
  } out_item_t;

  // Request from the sequencer to the entry store
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [VAL_W-1:0]  wr_data;
    logic [IDX_W-1:0]         rd_addr;
  } bld_mem_req_t;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  // Step a ring slot forward, wrapping at the capacity
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] s);
    ring_inc = (s == LAST_SLOT) ? '0 : IDX_W'(s + 1'b1);
  endfunction

  // Step a ring slot back, wrapping at zero
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] s);
    ring_dec = (s == '0) ? LAST_SLOT : IDX_W'(s - 1'b1);
  endfunction

  // Ring slot of a list position; front + pos stays below twice the capacity
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(front) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    slot_at = sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/bld_store.sv]
// Entry store of the list: one write port, one registered read port, key compare.
`default_nettype none
module bld_store (
  input  wire logic                           clk,
  input  wire bld_pkg::bld_mem_req_t          req,
  input  wire logic signed [bld_pkg::VAL_W-1:0] key,
  output logic signed [bld_pkg::VAL_W-1:0]    rd_data,
  output logic                                hit
);
  import bld_pkg::*;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.rd_addr];
  end

  // Shared compare against the search key
  assign rd_data = rd_data_r;
  assign hit     = (rd_data_r == key);

endmodule
`default_nettype wire

[rtl/bounded_list_deque_core.sv]
// Top level of the bounded list deque: handshakes, sequencer and list state.
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values, kept as a ring in a
// single-port-read entry store with a front slot and an element count. Every
// item gives one status result except list mode, which gives one result per
// element with last set on the final one; modes 6 and 7 are dropped silently.
// The one read port of the entry store sets the pace. Insert and delete at
// either end are done when the item is taken, the status sitting in the
// output register on the next cycle. Delete by value streams one entry per
// cycle through the compare, then closes the gap one entry per cycle. List
// mode handles each element in an address step, then an output register
// load step, and waits in the latter while the output side stalls.
// The block takes no new item until the current one is finished; it does
// take one while its last result is being handed over.
module bounded_list_deque_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bld_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bld_pkg::out_item_t        out_data
);
  import bld_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SRCH  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_LRD   = 5'b01000,
    S_LOUT  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]         iss_pos_r, iss_pos_nxt;
  logic [IDX_W-1:0]         iss_slot_r, iss_slot_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]         cmp_pos_r, cmp_pos_nxt;
  logic [IDX_W-1:0]         cmp_slot_r, cmp_slot_nxt;
  logic                     wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]         wr_slot_r, wr_slot_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  bld_mem_req_t             mem_req;
  logic signed [VAL_W-1:0]  rd_data;
  logic                     hit;
  logic                     out_free;
  logic                     in_fire;
  logic                     is_full;
  logic                     is_empty;
  logic [CNT_W-1:0]         cnt_m1;

  bld_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .key     (key_r),
    .rd_data (rd_data),
    .hit     (hit)
  );

  // The output register is free once empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign is_full  = (cnt_r == FULL_CNT);
  assign is_empty = (cnt_r == '0);
  assign cnt_m1   = CNT_W'(cnt_r - 1'b1);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    iss_pos_nxt   = iss_pos_r;
    iss_slot_nxt  = iss_slot_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_pos_nxt   = cmp_pos_r;
    cmp_slot_nxt  = cmp_slot_r;
    wr_pend_nxt   = wr_pend_r;
    wr_slot_nxt   = wr_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;

    // The read port always follows the walk pointer
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = wr_slot_r;
    mem_req.wr_data = rd_data;
    mem_req.rd_addr = iss_slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Default to a status-only result; list and search override
          out_item_nxt.element = '0;
          out_item_nxt.last    = 1'b1;
          out_item_nxt.status  = ST_OK;
          iss_pos_nxt          = '0;
          iss_slot_nxt         = front_r;
          cmp_vld_nxt          = 1'b0;
          wr_pend_nxt          = 1'b0;
          key_nxt              = in_data.value;
          case (in_data.mode)
            MODE_INS_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                front_nxt       = ring_dec(front_r);
                cnt_nxt         = CNT_W'(cnt_r + 1'b1);
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ring_dec(front_r);
                mem_req.wr_data = in_data.value;
              end
            end
            MODE_INS_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cnt_nxt         = CNT_W'(cnt_r + 1'b1);
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = slot_at(front_r, cnt_r);
                mem_req.wr_data = in_data.value;
              end
            end
            MODE_DEL_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                front_nxt = ring_inc(front_r);
                cnt_nxt   = cnt_m1;
              end
            end
            MODE_DEL_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            MODE_DEL_VALUE: begin
              if (is_empty) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            MODE_LIST: begin
              if (is_empty) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_LRD;
              end
            end
            default: begin
              // Unused modes: drop the item, no result
            end
          endcase
        end
      end

      S_SRCH: begin
        // Compare the entry read last cycle while the next one is fetched
        if (cmp_vld_r && hit) begin
          state_nxt    = S_SHIFT;
          iss_pos_nxt  = CNT_W'(cmp_pos_r + 1'b1);
          iss_slot_nxt = ring_inc(cmp_slot_r);
          wr_pend_nxt  = 1'b0;
        end else if (cmp_vld_r && (cmp_pos_r == cnt_m1)) begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_NOTFOUND;
        end else if (iss_pos_r < cnt_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_pos_nxt  = iss_pos_r;
          cmp_slot_nxt = iss_slot_r;
          iss_pos_nxt  = CNT_W'(iss_pos_r + 1'b1);
          iss_slot_nxt = ring_inc(iss_slot_r);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
      end

      S_SHIFT: begin
        // Write back the entry fetched last cycle one slot nearer the front
        mem_req.wr_en = wr_pend_r;
        if (iss_pos_r < cnt_r) begin
          wr_pend_nxt  = 1'b1;
          wr_slot_nxt  = iss_slot_r;
          iss_pos_nxt  = CNT_W'(iss_pos_r + 1'b1);
          iss_slot_nxt = ring_inc(iss_slot_r);
          if (wr_pend_r) begin
            wr_slot_nxt = iss_slot_r;
          end
          wr_slot_nxt = ring_dec(iss_slot_r);
        end else begin
          wr_pend_nxt         = 1'b0;
          cnt_nxt             = cnt_m1;
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_OK;
        end
      end

      S_LRD: begin
        // Read address is presented; data lands in the store's register
        state_nxt = S_LOUT;
      end

      S_LOUT: begin
        // Hold the read address until the output register takes the element
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_item_nxt.status  = ST_OK;
          out_item_nxt.element = rd_data;
          out_item_nxt.last    = (iss_pos_r == cnt_m1);
          if (iss_pos_r == cnt_m1) begin
            state_nxt = S_IDLE;
          end else begin
            iss_pos_nxt  = CNT_W'(iss_pos_r + 1'b1);
            iss_slot_nxt = ring_inc(iss_slot_r);
            state_nxt    = S_LRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk pointers, key and result payload
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    iss_pos_r  <= iss_pos_nxt;
    iss_slot_r <= iss_slot_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    wr_slot_r  <= wr_slot_nxt;
    out_item_r <= out_item_nxt;
  end

  // Element count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("element count above capacity");

  // An accepted insert into a list with room grows it by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_full &&
     (in_data.mode == MODE_INS_FRONT || in_data.mode == MODE_INS_BACK))
    |=> (cnt_r == CNT_W'($past(cnt_r) + 1'b1)))
    else $error("insert did not grow the list");

  // The gap-closing walk never runs past the end of the list
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (iss_pos_r <= cnt_r))
    else $error("shift walk beyond list end");

  // A result that is not ok always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status != ST_OK)) |-> out_item_r.last)
    else $error("error status without last mark");

  // The walk only runs on a non-empty list
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_LRD || state_r == S_LOUT) |-> !is_empty)
    else $error("walk on an empty list");

endmodule
`default_nettype wire

[tb/tb_bounded_list_deque_core.sv]
// Self-checking testbench for the bounded list deque core.
`timescale 1ns / 1ps

module tb_bounded_list_deque_core;
  import bld_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 300;            // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000;           // cycles with no handshake at all
  localparam int TAIL_CYCLES  = 4 * CAPACITY + 16;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Mode codes the block must drop without a trace
  localparam mode_t MODE_SPARE_6 = mode_t'(3'd6);
  localparam mode_t MODE_SPARE_7 = mode_t'(3'd7);

  // Shadow copy of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [VAL_W-1:0] shadow_slots [CAPACITY];
    logic [IDX_W-1:0]        shadow_front;
    logic [CNT_W-1:0]        shadow_count;
    out_item_t               awaited_results [$];
    int errors, items_taken, items_dropped, results_seen, peak_count;
    int status_hits [4];

    function new();
      shadow_front = '0;
      shadow_count = '0;
      errors = 0; items_taken = 0; items_dropped = 0; results_seen = 0; peak_count = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
    endfunction

    function int slot_of(int pos);
      return (int'(shadow_front) + pos) % CAPACITY;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void owe_status(status_t st);
      out_item_t r;
      r.status  = st;
      r.element = '0;
      r.last    = 1'b1;
      awaited_results.push_back(r);
    endfunction

    // Apply one accepted item to the shadow list and queue what it must produce
    function void note_item(in_item_t it);
      out_item_t r;
      int hit;
      int p;
      items_taken++;
      case (it.mode)
        MODE_INS_FRONT, MODE_INS_BACK: begin
          if (shadow_count == CAPACITY) begin
            owe_status(ST_FULL);
          end else begin
            if (it.mode == MODE_INS_FRONT) begin
              shadow_front = IDX_W'((int'(shadow_front) + CAPACITY - 1) % CAPACITY);
              shadow_slots[shadow_front] = it.value;
            end else begin
              shadow_slots[slot_of(shadow_count)] = it.value;
            end
            shadow_count++;
            owe_status(ST_OK);
          end
        end
        MODE_DEL_FRONT, MODE_DEL_BACK: begin
          if (shadow_count == 0) begin
            owe_status(ST_EMPTY);
          end else begin
            if (it.mode == MODE_DEL_FRONT) begin
              shadow_front = IDX_W'((int'(shadow_front) + 1) % CAPACITY);
            end
            shadow_count--;
            owe_status(ST_OK);
          end
        end
        MODE_DEL_VALUE: begin
          if (shadow_count == 0) begin
            owe_status(ST_EMPTY);
          end else begin
            hit = -1;
            for (p = 0; p < shadow_count && hit < 0; p++) begin
              if (shadow_slots[slot_of(p)] == it.value) hit = p;
            end
            if (hit < 0) begin
              owe_status(ST_NOTFOUND);
            end else begin
              // close up the later entries behind the removed one
              for (p = hit; p + 1 < shadow_count; p++) begin
                shadow_slots[slot_of(p)] = shadow_slots[slot_of(p + 1)];
              end
              shadow_count--;
              owe_status(ST_OK);
            end
          end
        end
        MODE_LIST: begin
          if (shadow_count == 0) begin
            owe_status(ST_EMPTY);
          end else begin
            for (p = 0; p < shadow_count; p++) begin
              r.status  = ST_OK;
              r.element = shadow_slots[slot_of(p)];
              r.last    = (p + 1 == shadow_count);
              awaited_results.push_back(r);
            end
          end
        end
        default: begin
          items_dropped++;
        end
      endcase
      if (shadow_count > peak_count) peak_count = shadow_count;
    endfunction

    // Compare one handed-over result with the oldest one owed
    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with none owed: status %0d element %0d last %0d",
                 $time, got.status, got.element, got.last);
        return;
      end
      want = awaited_results.pop_front();
      status_hits[want.status]++;
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
      end
      if (got.element !== want.element) begin
        errors++;
        $display("%0t: element mismatch, expected %0d actual %0d",
                 $time, want.element, got.element);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0d actual %0d",
                 $time, want.last, got.last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  list_scoreboard sb = new();

  bit calm     = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off
  int quiet_cycles = 0;

  bounded_list_deque_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: mostly ready, drops ready now and then, and serves the one long
  // hold-off, counting it down here so the sender can keep pushing meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Check every result handed over at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles, %0d results still owed",
               $time, QUIET_LIMIT, sb.pending());
      $display("[bounded_list_deque_core] ERROR");
      $finish;
    end
  end

  // Offer one item, idling now and then first; hold it until taken, then note
  // it straight away so the next choice of value sees the updated list.
  task automatic send(input mode_t m, input logic signed [VAL_W-1:0] v);
    in_item_t it;
    it.mode  = m;
    it.value = v;
    while (!calm && $urandom_range(0, 99) < 7) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mix small repeated values (so duplicates occur), extremes, live entries
  // for a likely delete hit, and plain random words.
  function automatic logic signed [VAL_W-1:0] pick_value(input bit prefer_live);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_live && sb.shadow_count != 0 && r < 70) begin
      return sb.shadow_slots[sb.slot_of($urandom_range(0, sb.shadow_count - 1))];
    end
    if (r < 20) return $urandom_range(0, 6) - 3;
    if (r < 30) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Insert until full, then push two more to see the full status
  task automatic fill_to_full(inout int n);
    while (sb.shadow_count < CAPACITY) begin
      send($urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK, pick_value(1'b0));
      n++;
    end
    repeat (2) begin
      send($urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK, pick_value(1'b0));
      n++;
    end
  endtask

  // Remove from either end or by value until empty, then probe the empty list
  task automatic drain_to_empty(inout int n);
    while (sb.shadow_count != 0) begin
      case ($urandom_range(0, 2))
        0:       send(MODE_DEL_FRONT, pick_value(1'b0));
        1:       send(MODE_DEL_BACK, pick_value(1'b0));
        default: send(MODE_DEL_VALUE, pick_value(1'b1));
      endcase
      n++;
    end
    send(MODE_DEL_VALUE, pick_value(1'b0));
    send(MODE_LIST, pick_value(1'b0));
    n += 2;
  endtask

  // One random item; inserts weigh insert_pct of a hundred, the spare modes
  // turn up rarely and are not counted as they do nothing.
  task automatic random_op(input int insert_pct, output bit counted);
    int    r;
    mode_t m;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < insert_pct) begin
      m = $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
    end else if (r < 86) begin
      case ($urandom_range(0, 2))
        0:       m = MODE_DEL_FRONT;
        1:       m = MODE_DEL_BACK;
        default: m = MODE_DEL_VALUE;
      endcase
    end else if (r < 97) begin
      m = MODE_LIST;
    end else begin
      m = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
      counted = 1'b0;
    end
    send(m, pick_value(m == MODE_DEL_VALUE));
  endtask

  initial begin
    int n;
    int insert_pct;
    bit took;
    bit refilled;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every delete and list on an empty list
    send(MODE_DEL_FRONT, '0);
    send(MODE_DEL_BACK, '0);
    send(MODE_DEL_VALUE, VAL_MIN);
    send(MODE_LIST, '0);
    // Empty list: insert back, list, delete front; insert front, delete back
    send(MODE_INS_BACK, VAL_MAX);
    send(MODE_LIST, '0);
    send(MODE_DEL_FRONT, '0);
    send(MODE_INS_FRONT, VAL_MIN);
    send(MODE_DEL_BACK, '0);
    // Build a short list with extremes and a repeated value
    send(MODE_INS_FRONT, '0);
    send(MODE_INS_BACK, -1);
    send(MODE_INS_FRONT, VAL_MIN);
    send(MODE_INS_BACK, VAL_MAX);
    send(MODE_INS_BACK, -1);
    // Missing value, then the first of two equal values, then the front one
    send(MODE_DEL_VALUE, 5);
    send(MODE_DEL_VALUE, -1);
    send(MODE_LIST, '0);
    send(MODE_SPARE_6, -1);
    send(MODE_SPARE_7, VAL_MAX);
    send(MODE_DEL_VALUE, VAL_MIN);
    send(MODE_LIST, '0);

    // Fill right up, then stall the receiver while the sender keeps offering
    // items, so the output backs up and input ready has to drop.
    // The directed items count toward the total.
    n = sb.items_taken - sb.items_dropped;
    fill_to_full(n);
    hold_req = 1'b1;
    send(MODE_LIST, pick_value(1'b0));
    send(MODE_INS_BACK, pick_value(1'b0));
    send(MODE_DEL_VALUE, pick_value(1'b1));
    send(MODE_LIST, pick_value(1'b0));
    n += 4;
    pause_until_drained();
    drain_to_empty(n);

    // Random phases alternate between growing and shrinking the list
    refilled = 1'b0;
    while (n < RANDOM_ITEMS) begin
      insert_pct = ((n / 25) % 2 == 0) ? 70 : 30;
      calm = (n >= 60 && n < 90);
      if (!refilled && n >= 95) begin
        refilled = 1'b1;
        fill_to_full(n);
        drain_to_empty(n);
      end
      random_op(insert_pct, took);
      if (took) begin
        n++;
        if (n % 40 == 0) pause_until_drained();
      end
    end
    calm = 1'b0;

    // Let the last results through and give any stray extras time to show
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run took %0d items (%0d in spare modes), checked %0d results,",
             sb.items_taken, sb.items_dropped, sb.results_seen);
    $display("list peaked at %0d of %0d.", sb.peak_count, CAPACITY);
    $display("Statuses seen: ok %0d, empty %0d, not found %0d, full %0d; %0d mismatches.",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_NOTFOUND],
             sb.status_hits[ST_FULL], sb.errors);
    if (sb.errors == 0) begin
      $display("[bounded_list_deque_core] OK");
    end else begin
      $display("[bounded_list_deque_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bld_pkg.sv
rtl/bld_store.sv
rtl/bounded_list_deque_core.sv
tb/tb_bounded_list_deque_core.sv
